/* rtl/core/distinct_square_count_max_search_top_assert.svh */
// Assertion macros for the distinct square counter.
// Included by distinct_square_count_max_search_top; no other dependencies.
`ifndef DISTINCT_SQUARE_COUNT_MAX_SEARCH_TOP_ASSERT_SVH
`define DISTINCT_SQUARE_COUNT_MAX_SEARCH_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DSQ_ASSERT_IMP(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);
`define DSQ_ASSERT_NXT(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);
`else
`define DSQ_ASSERT_IMP(lbl, clk, rst, ant, cons, msg)
`define DSQ_ASSERT_NXT(lbl, clk, rst, ant, cons, msg)
`endif
`endif

/* rtl/core/dsq_pkg.sv */
// Shared constants and helper functions for the distinct square counter.
// No dependencies.
package dsq_pkg;

  localparam int MAX_BITS  = 63;
  localparam int HALF_BITS = MAX_BITS / 2;
  localparam int LEN_W     = 6;
  localparam int H_W       = $clog2(HALF_BITS + 1);
  localparam int POS_W     = $clog2(MAX_BITS);
  localparam int CNT_W     = 10;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

  // Full-width bit reversal; callers shift the result down to the live length.
  function automatic logic [MAX_BITS-1:0] reverse_word(input logic [MAX_BITS-1:0] w);
    logic [MAX_BITS-1:0] r;
    for (int k = 0; k < MAX_BITS; k++) begin
      r[k] = w[MAX_BITS-1-k];
    end
    return r;
  endfunction

endpackage

/* rtl/core/distinct_square_count_max_search_top.sv */
// Distinct square counter with running maximum, top level.
// Depends on dsq_pkg and distinct_square_count_max_search_top_assert.svh.
//
// Each input word carries a candidate binary word whose low word_length bits
// are used; higher bits are masked off. The block first checks whether the
// word is the representative of its symmetry class (an odd word is dropped if
// it is below the complement of its reversal, an even word if it is above its
// reversal). For a kept word it counts distinct squares: for every half length
// h it walks every position p, compares the two adjacent h-bit segments, and
// counts an equal pair only if no earlier square of the same half length had
// the same root. One half-length and position pair is examined per cycle by a
// single shared compare unit; the duplicate check is a parallel compare of the
// current root against every earlier position flagged as a square. A kept word
// passes through a reversal step, a filter step, a scan of each half length (a
// setup step, then a step for each position) and a step that loads the result;
// a skipped word, or one shorter than two bits, goes from the filter straight to
// the load step. The sequencer then returns to its idle state before it can take
// the next word, and it waits in its last step for as long as the previous
// result is still held by the receiver. Input is taken only while the sequencer
// is idle, but a finished result sits in its own output register, so the next
// word is accepted while the previous result still waits. Input is stalled
// during reset. The running maximum is cleared by reset. The word_length
// register resets to 16 and must only be written while the block is idle.
module distinct_square_count_max_search_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [dsq_pkg::LEN_W-1:0]     cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dsq_pkg::MAX_BITS-1:0]  word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsq_pkg::CNT_W-1:0]     square_count,
  output logic                          skipped,
  output logic                          new_max,
  output logic                          at_max,
  output logic [dsq_pkg::CNT_W-1:0]     running_max
);

  `include "distinct_square_count_max_search_top_assert.svh"

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REV  = 3'd1;
  localparam logic [2:0] ST_FILT = 3'd2;
  localparam logic [2:0] ST_HINIT = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [dsq_pkg::MAX_BITS-1:0]  ALL_ONES  = '1;
  localparam logic [dsq_pkg::HALF_BITS-1:0] HALF_ONES = '1;

  logic [2:0]                        state;
  logic [dsq_pkg::LEN_W-1:0]         word_length;
  logic [dsq_pkg::MAX_BITS-1:0]      w_reg;
  logic [dsq_pkg::MAX_BITS-1:0]      rev_reg;
  logic [dsq_pkg::MAX_BITS-1:0]      sa;
  logic [dsq_pkg::MAX_BITS-1:0]      sb;
  logic [dsq_pkg::HALF_BITS-1:0]     hmask;
  logic [dsq_pkg::H_W-1:0]           h;
  logic [dsq_pkg::POS_W-1:0]         p;
  logic [dsq_pkg::POS_W-1:0]         p_last;
  logic [dsq_pkg::MAX_BITS-1:0]      flags;
  logic [dsq_pkg::CNT_W-1:0]         cnt;
  logic                              skip_reg;
  logic [dsq_pkg::CNT_W-1:0]         best_count;

  logic [dsq_pkg::MAX_BITS-1:0]      word_mask;
  logic [dsq_pkg::LEN_W-1:0]         len_gap;
  logic                              skip_now;
  logic [dsq_pkg::MAX_BITS-1:0]      lane_hit;
  logic                              seen;
  logic                              seg_eq;
  logic [dsq_pkg::H_W:0]             h_inc;
  logic                              more_h;
  logic                              out_free;
  logic                              cnt_gt;
  logic [dsq_pkg::CNT_W-1:0]         best_next;

  // The mask, reversal shift and length gap all follow from the live length.
  assign len_gap   = dsq_pkg::LEN_W'(dsq_pkg::MAX_BITS) - word_length;
  assign word_mask = ALL_ONES >> len_gap;

  // Class filter: odd words against the complement of the reversal, even
  // words against the reversal itself.
  assign skip_now = w_reg[0] ? (w_reg < (~rev_reg & word_mask)) : (w_reg > rev_reg);

  // Shared segment compare: root at p against the segment that follows it.
  assign seg_eq = ~|((sa[dsq_pkg::HALF_BITS-1:0] ^ sb[dsq_pkg::HALF_BITS-1:0]) & hmask);

  // Duplicate check: each lane holds the segment at a fixed earlier position.
  for (genvar g = 0; g < dsq_pkg::MAX_BITS; g++) begin : g_lane
    logic [dsq_pkg::MAX_BITS-1:0] lane_word;
    assign lane_word   = w_reg >> g;
    assign lane_hit[g] = ~|((lane_word[dsq_pkg::HALF_BITS-1:0]
                             ^ sa[dsq_pkg::HALF_BITS-1:0]) & hmask);
  end
  assign seen = |(lane_hit & flags);

  // Another half length fits when twice it does not exceed the length.
  assign h_inc  = {1'b0, h} + (dsq_pkg::H_W + 1)'(1);
  assign more_h = {h_inc, 1'b0} <= (dsq_pkg::H_W + 2)'(word_length);

  assign out_free  = !out_valid || !out_stall;
  assign cnt_gt    = !skip_reg && (cnt > best_count);
  assign best_next = cnt_gt ? cnt : best_count;

  assign in_stall = rst || (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= dsq_pkg::LEN_RESET;
    end else if (cfg_write_en) begin
      word_length <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      best_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A new result is loaded as the old one leaves or once the register is empty.
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            w_reg    <= word & word_mask;
            cnt      <= '0;
            skip_reg <= 1'b0;
            state    <= ST_REV;
          end
        end
        ST_REV: begin
          rev_reg <= dsq_pkg::reverse_word(w_reg) >> len_gap;
          state   <= ST_FILT;
        end
        ST_FILT: begin
          skip_reg <= skip_now;
          h        <= dsq_pkg::H_W'(1);
          if (skip_now || (word_length < dsq_pkg::LEN_W'(2))) begin
            state <= ST_DONE;
          end else begin
            state <= ST_HINIT;
          end
        end
        ST_HINIT: begin
          sa     <= w_reg;
          sb     <= w_reg >> h;
          hmask  <= HALF_ONES >> (dsq_pkg::H_W'(dsq_pkg::HALF_BITS) - h);
          p      <= '0;
          p_last <= word_length - dsq_pkg::POS_W'({h, 1'b0});
          flags  <= '0;
          state  <= ST_SCAN;
        end
        ST_SCAN: begin
          if (seg_eq && !seen) begin
            cnt      <= cnt + dsq_pkg::CNT_W'(1);
            flags[p] <= 1'b1;
          end
          if (p == p_last) begin
            h <= h_inc[dsq_pkg::H_W-1:0];
            if (more_h) begin
              state <= ST_HINIT;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            p  <= p + dsq_pkg::POS_W'(1);
            sa <= sa >> 1;
            sb <= sb >> 1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            square_count <= cnt;
            skipped      <= skip_reg;
            new_max      <= cnt_gt;
            at_max       <= !skip_reg && (cnt == best_next);
            running_max  <= best_next;
            best_count   <= best_next;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A skipped word reports nothing but the flag and the old maximum.
  `DSQ_ASSERT_IMP(a_skip_quiet, clk, rst, out_valid && skipped,
                  square_count == '0 && !new_max && !at_max, "skipped word with a result")
  // A word at the maximum reports the maximum as its count.
  `DSQ_ASSERT_IMP(a_at_max_count, clk, rst, out_valid && at_max,
                  square_count == running_max, "at_max without matching count")
  // The scan position never runs past the last position of its half length.
  `DSQ_ASSERT_IMP(a_scan_bound, clk, rst, state == ST_SCAN, p <= p_last,
                  "scan position beyond last position")
  // The running maximum never decreases.
  `DSQ_ASSERT_NXT(a_best_mono, clk, rst, 1'b1, best_count >= $past(best_count),
                  "running maximum decreased")

endmodule

/* test/distinct_square_count_max_search_top_tb.sv */
// Testbench for distinct_square_count_max_search_top: drives candidate words and checks
// every result against a predictor of the square count, symmetry filter and running max
// (or a typed table row). Depends on dsq_pkg and the top level; needs no other files.
module distinct_square_count_max_search_top_tb;

  localparam int WBITS = dsq_pkg::MAX_BITS;
  localparam int CW    = dsq_pkg::CNT_W;

  // Watchdog limit in cycles with no word moving on either side. The slowest word is
  // a kept one of length 63, and the long receiver hold-off adds to the wait.
  localparam int IDLE_LIMIT   = 8000;
  localparam int LONG_HOLD    = 300;
  localparam int PRESSURE_LEN = 8;
  localparam int TAIL_CYCLES  = 1200;
  localparam int MAX_REPORTS  = 200;
  localparam int NUM_ROWS     = 20;
  localparam int NUM_PHASES   = 19;

  typedef struct packed {
    logic [CW-1:0] square_count;
    logic          skipped;
    logic          new_max;
    logic          at_max;
    logic [CW-1:0] running_max;
  } square_result_t;

  // One row of the directed table. Where typed is set, the e_* fields are the result
  // that must come back; otherwise the predictor supplies it.
  typedef struct {
    int               len;
    logic [WBITS-1:0] bits;
    bit               typed;
    int               e_count;
    int               e_skip;
    int               e_new;
    int               e_at;
    int               e_max;
  } word_row_t;

  localparam logic [WBITS-1:0] ALL_ONES = {WBITS{1'b1}};

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_write_en;
  logic [dsq_pkg::LEN_W-1:0]  cfg_write_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [WBITS-1:0]           word;
  logic                       out_valid;
  logic                       out_stall;
  logic [CW-1:0]              square_count;
  logic                       skipped;
  logic                       new_max;
  logic                       at_max;
  logic [CW-1:0]              running_max;

  distinct_square_count_max_search_top u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .word           (word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .square_count   (square_count),
    .skipped        (skipped),
    .new_max        (new_max),
    .at_max         (at_max),
    .running_max    (running_max)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: the word length as last written and the running maximum.
  int active_length;
  int best_square_count;

  square_result_t expected_results[$];

  int  errors;
  int  results_checked;
  int  skipped_seen;
  int  new_max_seen;
  int  idle_cycles;
  int  send_gap_pct;
  int  sink_stall_pct;
  bit  quiet;
  bit  hold_req;

  square_result_t got_res;
  square_result_t want_res;

  // Directed table: reset length, lengths of zero and one, the shortest legal length,
  // masking of bits above the length, both branches of the symmetry filter, and a zero
  // count while the maximum is still zero.
  word_row_t dir_rows [NUM_ROWS] = '{
    '{16, 63'h1,                 1'b1, 0, 1, 0, 0, 0},
    '{0,  ALL_ONES,              1'b1, 0, 0, 0, 1, 0},
    '{1,  ALL_ONES,              1'b1, 0, 0, 0, 1, 0},
    '{1,  63'h0,                 1'b1, 0, 0, 0, 1, 0},
    '{2,  63'h2,                 1'b1, 0, 1, 0, 0, 0},
    '{2,  63'h3,                 1'b1, 1, 0, 1, 1, 1},
    '{2,  63'h1,                 1'b0, 0, 0, 0, 0, 0},
    '{2,  63'h0,                 1'b0, 0, 0, 0, 0, 0},
    '{16, 63'h0,                 1'b1, 8, 0, 1, 1, 8},
    '{16, ALL_ONES,              1'b1, 8, 0, 0, 1, 8},
    '{16, 63'h7FFF_FFFF_FFFF_0000, 1'b1, 8, 0, 0, 1, 8},
    '{16, 63'h8000,              1'b1, 0, 1, 0, 0, 8},
    '{16, 63'h5555,              1'b0, 0, 0, 0, 0, 0},
    '{16, 63'hAAAA,              1'b0, 0, 0, 0, 0, 0},
    '{16, 63'h3333,              1'b0, 0, 0, 0, 0, 0},
    '{16, 63'h4E4E,              1'b0, 0, 0, 0, 0, 0},
    '{4,  63'h7FFF_FFFF_FFFF_FFF6, 1'b0, 0, 0, 0, 0, 0},
    '{8,  63'hCC,                1'b0, 0, 0, 0, 0, 0},
    '{12, 63'hABC,               1'b0, 0, 0, 0, 0, 0},
    '{6,  63'h2D,                1'b0, 0, 0, 0, 0, 0}
  };

  // Random phases run from short to long words so that the running maximum keeps
  // climbing and new maxima keep turning up.
  int phase_len [NUM_PHASES] = '{0, 1, 2, 3, 4, 5, 6, 8, 10, 12, 14, 16, 20, 24, 28, 32,
                                 40, 48, 63};

  function automatic logic [WBITS-1:0] low_ones(input int n);
    if (n >= WBITS) return ALL_ONES;
    return (WBITS'(1) << n) - WBITS'(1);
  endfunction

  function automatic logic [WBITS-1:0] mirror_word(input logic [WBITS-1:0] w, input int n);
    logic [WBITS-1:0] r;
    r = '0;
    for (int k = 0; k < n; k++) r[n-1-k] = w[k];
    return r;
  endfunction

  // For each half length, every equal pair of adjacent segments is a square; a root
  // already seen at the same half length is not counted again.
  function automatic int count_distinct_squares(input logic [WBITS-1:0] w, input int n);
    logic [WBITS-1:0] roots [64];
    logic [WBITS-1:0] m;
    logic [WBITS-1:0] a;
    logic [WBITS-1:0] b;
    int               total;
    int               found;
    bit               seen;
    total = 0;
    for (int h = 1; h <= n / 2; h++) begin
      m = low_ones(h);
      found = 0;
      for (int p = 0; p + 2 * h <= n; p++) begin
        a = (w >> p) & m;
        b = (w >> (p + h)) & m;
        if (a == b) begin
          seen = 1'b0;
          for (int k = 0; k < found; k++) if (roots[k] == a) seen = 1'b1;
          if (!seen) begin
            roots[found] = a;
            found++;
            total++;
          end
        end
      end
    end
    return total;
  endfunction

  // Works out the result for one accepted word and advances the running maximum.
  function automatic square_result_t predict_square_result(input logic [WBITS-1:0] raw);
    square_result_t res;
    int               n;
    int               cnt;
    logic [WBITS-1:0] mask;
    logic [WBITS-1:0] w;
    logic [WBITS-1:0] r;
    bit               skip;
    n = (active_length > WBITS) ? WBITS : active_length;
    mask = low_ones(n);
    w = raw & mask;
    r = mirror_word(w, n);
    // Odd words are compared with the complement of their reversal, even words with it.
    skip = w[0] ? (w < (~r & mask)) : (w > r);
    res = '0;
    res.skipped = skip;
    if (!skip) begin
      cnt = count_distinct_squares(w, n) & 'h3FF;
      res.square_count = CW'(cnt);
      if (cnt > best_square_count) begin
        best_square_count = cnt;
        res.new_max = 1'b1;
      end
      res.at_max = (cnt == best_square_count);
    end
    res.running_max = CW'(best_square_count);
    return res;
  endfunction

  // Candidate words: half fully random, a quarter built by repeating a short root
  // (rich in squares, sometimes with one bit flipped), a quarter sparse.
  function automatic logic [WBITS-1:0] make_candidate_word();
    logic [WBITS-1:0] w;
    logic [31:0]      root;
    int               root_len;
    w = '0;
    case ($urandom_range(0, 3))
      0, 1: w = WBITS'({$urandom, $urandom});
      2: begin
        root_len = $urandom_range(1, 8);
        root = $urandom;
        for (int k = 0; k < WBITS; k++) w[k] = root[k % root_len];
        if ($urandom_range(0, 1) == 1) w[$urandom_range(0, WBITS - 1)] ^= 1'b1;
      end
      default: begin
        repeat ($urandom_range(1, 4)) w[$urandom_range(0, WBITS - 1)] = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 20;
      default: return 50;
    endcase
  endfunction

  // Offers one word, holding it until the block takes it. The expectation is queued at
  // the edge that accepts the word, so the predictor sees words in acceptance order.
  task automatic send_word(input logic [WBITS-1:0] w, input bit typed,
                           input square_result_t typed_res);
    square_result_t res;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    word     <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    res = predict_square_result(w);
    if (typed) res = typed_res;
    expected_results = {expected_results, res};
  endtask

  // The length register may only change while the block is idle, which is the case
  // once every outstanding result has come back.
  task automatic set_length(input int len);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= dsq_pkg::LEN_W'(len);
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    active_length = len;
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  // Result checker: each word leaving the block is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_res = '{square_count, skipped, new_max, at_max, running_max};
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got count %0d skipped %0b",
                   $time, square_count, skipped);
      end else begin
        want_res = expected_results.pop_front();
        check_field("square_count", want_res.square_count, got_res.square_count);
        check_field("skipped", want_res.skipped, got_res.skipped);
        check_field("new_max", want_res.new_max, got_res.new_max);
        check_field("at_max", want_res.at_max, got_res.at_max);
        check_field("running_max", want_res.running_max, got_res.running_max);
        results_checked++;
        if (want_res.skipped) skipped_seen++;
        if (want_res.new_max) new_max_seen++;
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("[distinct_square_count_max_search_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stalls in random bursts, or for one long stretch when asked, so that the
  // block fills its output register and has to stall its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    square_result_t typed_res;
    int             n_items;
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    word           = '0;
    errors         = 0;
    results_checked = 0;
    skipped_seen   = 0;
    new_max_seen   = 0;
    idle_cycles    = 0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    send_gap_pct   = 20;
    sink_stall_pct = 20;
    active_length     = dsq_pkg::LEN_RESET;
    best_square_count = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The first row runs at the reset length without any write.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].len != active_length) set_length(dir_rows[i].len);
      typed_res = '{CW'(dir_rows[i].e_count), dir_rows[i].e_skip[0], dir_rows[i].e_new[0],
                    dir_rows[i].e_at[0], CW'(dir_rows[i].e_max)};
      send_word(dir_rows[i].bits, dir_rows[i].typed, typed_res);
    end

    // Random part, one phase per word length. Short words dominate since a kept word
    // takes longer to scan the longer it is.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_length(phase_len[ph]);
      quiet          = (ph >= NUM_PHASES - 2);
      send_gap_pct   = pick_idle_pct();
      sink_stall_pct = pick_idle_pct();
      if (phase_len[ph] == PRESSURE_LEN) begin
        // The sender keeps offering back to back while the receiver holds off.
        send_gap_pct = 0;
        hold_req     = 1'b1;
      end
      n_items = (phase_len[ph] <= 16) ? 90 : (phase_len[ph] <= 32) ? 60 :
                (phase_len[ph] <= 48) ? 30 : 25;
      repeat (n_items) send_word(make_candidate_word(), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // Give a stray result time to show up.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results over %0d word lengths: %0d skipped, %0d new maxima,",
             results_checked, NUM_PHASES, skipped_seen, new_max_seen);
    $display("final running maximum %0d, long receiver hold-off included", best_square_count);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[distinct_square_count_max_search_top] OK");
    end else begin
      $display("[distinct_square_count_max_search_top] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/dsq_pkg.sv
rtl/core/distinct_square_count_max_search_top.sv
test/distinct_square_count_max_search_top_tb.sv
